// ----- rtl/ira_pkg.sv -----
// Shared constants, codes and types of the interval register allocator.
`timescale 1ns / 1ps
package ira_pkg;

  localparam int NUM_REGS    = 16;
  localparam int MAX_PER_REG = 32;
  localparam int INDEX_BITS  = 16;

  localparam int REG_W   = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;
  localparam int SLOT_W  = (MAX_PER_REG > 1) ? $clog2(MAX_PER_REG) : 1;
  localparam int CNT_W   = $clog2(MAX_PER_REG + 1);
  localparam int ADDR_W  = REG_W + SLOT_W;
  localparam int RAM_DEPTH = 1 << ADDR_W;
  localparam int FIELD_W = 16;
  localparam int STORE_W = 2 * FIELD_W;

  localparam logic [FIELD_W-1:0] IDX_MASK =
      (INDEX_BITS >= FIELD_W) ? {FIELD_W{1'b1}}
                              : FIELD_W'((33'd1 << INDEX_BITS) - 33'd1);

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_CLEAR = 1'b1;

  typedef enum logic [1:0] {
    ST_PLACED  = 2'd0,
    ST_SPILL   = 2'd1,
    ST_CLEARED = 2'd2
  } status_t;

  typedef struct packed {
    logic clr;
    logic en;
  } cmp_ctl_t;

endpackage

// ----- rtl/ira_in_if.sv -----
// Input channel: one interval or clear request per word.
`timescale 1ns / 1ps
interface ira_in_if;
  logic        valid;
  logic        ready;
  logic        opcode;
  logic [15:0] first_use;
  logic [15:0] last_use;

  modport source (output valid, opcode, first_use, last_use, input ready);
  modport sink (input valid, opcode, first_use, last_use, output ready);
endinterface

// ----- rtl/ira_out_if.sv -----
// Output channel: one allocation result per word.
`timescale 1ns / 1ps
interface ira_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic [3:0] reg_number;

  modport source (output valid, status, reg_number, input ready);
  modport sink (input valid, status, reg_number, output ready);
endinterface

// ----- rtl/ira_cfg_if.sv -----
// Configuration channel: write word for the usable register mask.
`timescale 1ns / 1ps
interface ira_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] usable_register_mask;

  modport source (output valid, usable_register_mask, input ready);
  modport sink (input valid, usable_register_mask, output ready);
endinterface

// ----- rtl/ira_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module ira_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 512,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/ira_cmp.sv -----
// Shared overlap compare unit with a sticky conflict flag.
`timescale 1ns / 1ps
module ira_cmp import ira_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  cmp_ctl_t           ctl,
  input  logic [STORE_W-1:0] entry,
  input  logic [FIELD_W-1:0] lo,
  input  logic [FIELD_W-1:0] hi,
  output logic               overlap_seen
);

  logic [FIELD_W-1:0] st_first;
  logic [FIELD_W-1:0] st_last;
  logic               overlap;

  assign st_first = entry[STORE_W-1:FIELD_W];
  assign st_last  = entry[FIELD_W-1:0];
  // Disjoint when the stored interval ends before or starts after the new one.
  assign overlap  = !((st_first > hi) || (st_last < lo));

  always_ff @(posedge clk) begin
    if (rst) begin
      overlap_seen <= 1'b0;
    end else if (ctl.clr) begin
      overlap_seen <= 1'b0;
    end else if (ctl.en && overlap) begin
      overlap_seen <= 1'b1;
    end
  end

endmodule

// ----- rtl/interval_register_allocator_core.sv -----
// Top level of the greedy interval register allocator.
`timescale 1ns / 1ps
// Greedy interval register allocator. Each input word either clears every
// register's interval list (opcode 1, result status 2) or offers a live
// interval [first_use, last_use]. The interval goes to the lowest usable,
// non-full register whose recorded intervals all lie wholly before or after
// it (status 0, reg_number set) and is recorded there; otherwise it spills
// (status 1). Intervals live in one RAM indexed by {register, slot}; a single
// compare unit walks the recorded entries of each examined register one per
// cycle, and a conflict ends a register's walk early; registers skipped by the
// mask or full are passed over without a walk. The input is ready only while the
// sequencer is idle; a finished result sits in an output register so the next
// word can enter while it waits. Fill counts are flip-flops cleared at reset and
// by a clear word, so the store needs no clearing pass. The mask may be written
// at any time the block is idle and resets to all ones.
module interval_register_allocator_core import ira_pkg::*; (
  input  logic clk,
  input  logic rst,
  ira_in_if.sink    in_ch,
  ira_out_if.source out_ch,
  ira_cfg_if.sink   cfg_ch
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_PICK,
    S_READ,
    S_DECIDE,
    S_EMIT
  } state_t;

  state_t state;

  logic [15:0]        mask;
  logic [CNT_W-1:0]   cnt [NUM_REGS];
  logic [FIELD_W-1:0] lo;
  logic [FIELD_W-1:0] hi;
  logic [REG_W-1:0]   r;
  logic [CNT_W-1:0]   k;
  logic               rd_valid;
  status_t            res_status;
  logic [REG_W-1:0]   res_reg;

  logic               out_valid;
  status_t            out_status;
  logic [3:0]         out_reg;

  logic [CNT_W-1:0]   n;
  logic               usable;
  logic               last_reg;
  logic               overlap_seen;
  cmp_ctl_t           cmp_ctl;

  logic               ram_we;
  logic [ADDR_W-1:0]  ram_waddr;
  logic [ADDR_W-1:0]  ram_raddr;
  logic [STORE_W-1:0] ram_wdata;
  logic [STORE_W-1:0] ram_rdata;

  // Current register's fill level and whether it may take the interval.
  assign n        = cnt[r];
  assign usable   = mask[r] && (n < CNT_W'(MAX_PER_REG));
  assign last_reg = (r == REG_W'(NUM_REGS - 1));

  // Stream entries 0..n-1 of the current register; write the new entry at slot n.
  always_comb begin
    ram_raddr   = {r, k[SLOT_W-1:0]};
    ram_waddr   = {r, n[SLOT_W-1:0]};
    ram_wdata   = {lo, hi};
    ram_we      = (state == S_DECIDE) && !overlap_seen;
    cmp_ctl.clr = (state == S_PICK);
    cmp_ctl.en  = rd_valid;
  end

  ira_ram #(
    .WIDTH(STORE_W),
    .DEPTH(RAM_DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  ira_cmp u_cmp (
    .clk         (clk),
    .rst         (rst),
    .ctl         (cmp_ctl),
    .entry       (ram_rdata),
    .lo          (lo),
    .hi          (hi),
    .overlap_seen(overlap_seen)
  );

  assign in_ch.ready       = (state == S_IDLE);
  assign cfg_ch.ready      = 1'b1;
  assign out_ch.valid      = out_valid;
  assign out_ch.status     = out_status;
  assign out_ch.reg_number = out_reg;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      rd_valid  <= 1'b0;
      mask      <= '1;
      for (int i = 0; i < NUM_REGS; i++) begin
        cnt[i] <= '0;
      end
    end else begin
      // Flag the read issued this cycle so the compare sees its data next cycle.
      rd_valid <= (state == S_READ) && !overlap_seen && (k != n);

      // Drop the held result once the sink takes it, unless a new one loads now.
      if (out_valid && out_ch.ready && (state != S_EMIT)) begin
        out_valid <= 1'b0;
      end

      if (cfg_ch.valid) begin
        mask <= cfg_ch.usable_register_mask;
      end

      unique case (state)
        S_IDLE: begin
          if (in_ch.valid) begin
            lo      <= in_ch.first_use & IDX_MASK;
            hi      <= in_ch.last_use & IDX_MASK;
            r       <= '0;
            res_reg <= '0;
            if (in_ch.opcode == OP_CLEAR) begin
              for (int i = 0; i < NUM_REGS; i++) begin
                cnt[i] <= '0;
              end
              res_status <= ST_CLEARED;
              state      <= S_EMIT;
            end else begin
              state <= S_PICK;
            end
          end
        end

        // Skip masked or full registers; otherwise start the entry walk.
        S_PICK: begin
          k <= '0;
          if (usable) begin
            state <= S_READ;
          end else if (last_reg) begin
            res_status <= ST_SPILL;
            res_reg    <= '0;
            state      <= S_EMIT;
          end else begin
            r <= r + REG_W'(1);
          end
        end

        // Issue one read per cycle; stop early on the first conflict.
        S_READ: begin
          if (overlap_seen || (k == n)) begin
            state <= S_DECIDE;
          end else begin
            k <= k + CNT_W'(1);
          end
        end

        S_DECIDE: begin
          if (!overlap_seen) begin
            cnt[r]     <= n + CNT_W'(1);
            res_status <= ST_PLACED;
            res_reg    <= r;
            state      <= S_EMIT;
          end else if (last_reg) begin
            res_status <= ST_SPILL;
            res_reg    <= '0;
            state      <= S_EMIT;
          end else begin
            r     <= r + REG_W'(1);
            state <= S_PICK;
          end
        end

        // Hold until the output register is free, then load it.
        S_EMIT: begin
          if (!out_valid || out_ch.ready) begin
            out_valid  <= 1'b1;
            out_status <= res_status;
            out_reg    <= 4'(res_reg);
            state      <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- test/ira_placement_checker.sv -----
// Placement predictor and result checker for the interval register allocator.
`timescale 1ns / 1ps
module ira_placement_checker import ira_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  ira_in_if         in_ch,
  ira_out_if        out_ch,
  ira_cfg_if        cfg_ch,
  output int        fail_count,
  output int        outstanding
);

  typedef struct packed {
    status_t    status;
    logic [3:0] reg_number;
  } placement_t;

  logic [FIELD_W-1:0] first_tbl [NUM_REGS][MAX_PER_REG];
  logic [FIELD_W-1:0] last_tbl  [NUM_REGS][MAX_PER_REG];
  int unsigned        fill_count [NUM_REGS];
  logic [15:0]        reg_mask;
  placement_t         placement_q [$];

  // First usable, non-full register with no overlap takes the interval.
  function automatic placement_t place_interval(logic [FIELD_W-1:0] lo,
                                                logic [FIELD_W-1:0] hi);
    placement_t res;
    bit         clash;
    res.status     = ST_SPILL;
    res.reg_number = '0;
    for (int r = 0; r < NUM_REGS; r++) begin
      if (!reg_mask[r] || fill_count[r] >= MAX_PER_REG) continue;
      clash = 1'b0;
      for (int k = 0; k < fill_count[r]; k++) begin
        if (!(first_tbl[r][k] > hi || last_tbl[r][k] < lo)) clash = 1'b1;
      end
      if (clash) continue;
      first_tbl[r][fill_count[r]] = lo;
      last_tbl[r][fill_count[r]]  = hi;
      fill_count[r]++;
      res.status     = ST_PLACED;
      res.reg_number = 4'(r);
      return res;
    end
    return res;
  endfunction

  task automatic log_failure(string msg);
    fail_count++;
    if (fail_count <= 10) $display("[%0t] %s", $realtime, msg);
  endtask

  always @(posedge clk) begin
    placement_t want;
    if (rst) begin
      for (int r = 0; r < NUM_REGS; r++) fill_count[r] = 0;
      reg_mask = 16'hFFFF;
      placement_q.delete();
      fail_count = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (placement_q.size() == 0) begin
          log_failure($sformatf("unexpected result: status %0d reg %0d",
                                out_ch.status, out_ch.reg_number));
        end else begin
          want = placement_q.pop_front();
          if (out_ch.status !== want.status)
            log_failure($sformatf("status: expected %0d, got %0d",
                                  want.status, out_ch.status));
          if (out_ch.reg_number !== want.reg_number)
            log_failure($sformatf("reg_number: expected %0d, got %0d",
                                  want.reg_number, out_ch.reg_number));
        end
      end
      if (cfg_ch.valid && cfg_ch.ready) reg_mask = cfg_ch.usable_register_mask;
      if (in_ch.valid && in_ch.ready) begin
        if (in_ch.opcode == OP_CLEAR) begin
          for (int r = 0; r < NUM_REGS; r++) fill_count[r] = 0;
          want.status     = ST_CLEARED;
          want.reg_number = '0;
        end else begin
          want = place_interval(in_ch.first_use & IDX_MASK,
                                in_ch.last_use & IDX_MASK);
        end
        placement_q = {placement_q, want};
      end
    end
    outstanding = placement_q.size();
  end

endmodule

// ----- test/tb.sv -----
// Testbench top: stimulus, handshake pacing and verdict for the allocator core.
`timescale 1ns / 1ps
module tb;
  import ira_pkg::*;

  localparam int HOLD_OFF_CYCLES = 400;
  // Bound on the slowest run of all words plus stalls, with a wide margin.
  localparam int CYCLE_LIMIT     = 4_000_000;
  localparam int PHASES          = 8;
  localparam int WORDS_PER_PHASE = 90;

  logic clk;
  logic rst;
  logic steady       = 1'b0;  // suppress random idling on both sides
  logic hold_off_req = 1'b0;  // ask the receiver for one long stall
  int   fail_count;
  int   outstanding;
  int   cycle_count  = 0;

  ira_in_if  in_ch ();
  ira_out_if out_ch ();
  ira_cfg_if cfg_ch ();

  interval_register_allocator_core uut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  ira_placement_checker placement_chk (
    .clk         (clk),
    .rst         (rst),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_ch      (cfg_ch),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Abort a hung run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Receiver: drop ready with a chance of 9 in 100 each cycle, hold it low for a long
  // stretch on request so the block backs up into its input.
  initial begin
    int held;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_ch.ready <= 1'b0;
        for (held = 0; held < HOLD_OFF_CYCLES; held++) @(negedge clk);
      end
      out_ch.ready <= steady || ($urandom_range(99) >= 9);
    end
  end

  // Offer one word, with random idle cycles ahead of it; return at the
  // falling edge after it was taken, with valid still high.
  task automatic send_word(input logic op, input logic [15:0] f,
                           input logic [15:0] l);
    while (!steady && $urandom_range(99) < 9) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.opcode    <= op;
    in_ch.first_use <= f;
    in_ch.last_use  <= l;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Stop offering and wait until every predicted result has been taken.
  // Always advance at least one edge so valid is not raised again in the
  // step where it was dropped.
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    do @(negedge clk); while (outstanding != 0);
  endtask

  // Write the usable register mask; only while the block is idle.
  task automatic write_mask(input logic [15:0] m);
    wait_drained();
    cfg_ch.valid                <= 1'b1;
    cfg_ch.usable_register_mask <= m;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
    @(negedge clk);
  endtask

  initial begin
    logic [15:0] f;
    logic [15:0] l;
    logic [15:0] base;
    logic [15:0] mask;
    int          style;
    int          n;
    int          phase_words;

    // Known values on every input from time zero.
    rst                         = 1'b1;
    in_ch.valid                 = 1'b0;
    in_ch.opcode                = OP_ALLOC;
    in_ch.first_use             = '0;
    in_ch.last_use              = '0;
    cfg_ch.valid                = 1'b0;
    cfg_ch.usable_register_mask = 16'hFFFF;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed part, reset mask (all registers usable).
    send_word(OP_CLEAR, 16'hFFFF, 16'hFFFF);  // clear ignores its fields
    send_word(OP_ALLOC, 16'h0000, 16'h0000);  // lowest point -> reg 0
    send_word(OP_ALLOC, 16'hFFFF, 16'hFFFF);  // highest point, disjoint -> reg 0
    send_word(OP_ALLOC, 16'h0000, 16'hFFFF);  // whole range -> reg 1
    send_word(OP_ALLOC, 16'h0000, 16'hFFFF);  // whole range again -> reg 2
    send_word(OP_ALLOC, 16'd100, 16'd50);     // reversed interval -> reg 0
    send_word(OP_ALLOC, 16'd75, 16'd75);      // inside the reversed pair, still fits
    send_word(OP_ALLOC, 16'h0001, 16'hFFFE);  // clashes with reg 0..2 -> reg 3
    send_word(OP_ALLOC, 16'd50, 16'd100);     // next free register
    // No usable register: every interval spills.
    write_mask(16'h0000);
    send_word(OP_ALLOC, 16'd10, 16'd20);
    send_word(OP_CLEAR, 16'h0000, 16'h0000);
    // Top register only.
    write_mask(16'h8000);
    send_word(OP_ALLOC, 16'h0000, 16'hFFFF);  // -> reg 15
    send_word(OP_ALLOC, 16'h1234, 16'h1234);  // clashes in reg 15 -> spill
    send_word(OP_CLEAR, 16'h5555, 16'hAAAA);
    send_word(OP_ALLOC, 16'hAAAA, 16'h5555);  // reversed, empty lists -> reg 15

    // Random phases. Each phase sets a mask and runs whole functions:
    // a clear word followed by a run of intervals of one shape.
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0, 7:    mask = 16'hFFFF;
        1:       mask = 16'h0001;
        2:       mask = 16'h8000;
        3:       mask = 16'h0000;
        default: mask = 16'($urandom);
      endcase
      write_mask(mask);
      steady = (p == 1);         // one long stretch with no idling at all
      if (p == 2) hold_off_req = 1'b1;

      phase_words = 0;
      while (phase_words < WORDS_PER_PHASE) begin
        if (p == 4) wait_drained();   // sender pauses until the block is empty
        style = $urandom_range(3);
        // Point runs go past one register's capacity to reach the full case.
        n     = (style == 1) ? $urandom_range(33, 60) : $urandom_range(8, 50);
        base  = 16'($urandom);
        send_word(OP_CLEAR, 16'($urandom), 16'($urandom));
        phase_words++;
        for (int i = 0; i < n; i++) begin
          case (style)
            0: begin                    // crowded window: many overlaps
              f = base + 16'($urandom_range(127));
              l = f + 16'($urandom_range(15));
            end
            1: begin                    // disjoint points, fill registers
              f = base + 16'(2 * i);
              l = f;
            end
            2: begin                    // any values, half of them reversed
              f = 16'($urandom);
              l = 16'($urandom);
            end
            default: begin              // nested and shared low ranges
              f = 16'($urandom_range(255));
              l = f + 16'($urandom_range(255));
            end
          endcase
          // A stray clear now and then breaks a function in the middle.
          if ($urandom_range(99) < 4) send_word(OP_CLEAR, f, l);
          else send_word(OP_ALLOC, f, l);
          phase_words++;
        end
      end
      steady = 1'b0;
    end

    // Drain, then let the output stay quiet for a while to catch extras.
    wait_drained();
    repeat (20) @(negedge clk);
    if (fail_count == 0 && outstanding == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
